>>> design/rxc_pkg.sv
// Package for the rotate/XOR chain cipher: types, constants and rotate helpers.
// No dependencies; used by every other design file.
package rxc_pkg;

    localparam int unsigned ROT_ENTRIES = 32;
    localparam int unsigned IDX_W       = $clog2(ROT_ENTRIES);
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned ADDR_W      = 3;

    localparam logic [WORD_W-1:0]  SEED_RESET = 32'd16;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

    // Register index (paddr[2])
    localparam logic REG_DECRYPT = 1'b0;
    localparam logic REG_SEED    = 1'b1;

    localparam logic [IDX_W-1:0] ROT_TABLE [ROT_ENTRIES] = '{
        5'd2,  5'd4,  5'd19, 5'd31, 5'd21, 5'd16, 5'd7,  5'd30,
        5'd9,  5'd18, 5'd23, 5'd28, 5'd1,  5'd5,  5'd9,  5'd19,
        5'd29, 5'd14, 5'd12, 5'd2,  5'd16, 5'd23, 5'd27, 5'd29,
        5'd17, 5'd6,  5'd4,  5'd14, 5'd17, 5'd21, 5'd22, 5'd23
    };

    typedef struct packed {
        logic              decrypt;
        logic [WORD_W-1:0] seed;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] chain;
        logic [IDX_W-1:0]  index;
    } t_chain;

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} >> s;
        return t[31:0];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] s);
        logic [15:0] t;
        t = {v, v} >> s;
        return t[7:0];
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] s);
        logic [15:0] t;
        t = {v, v} << s;
        return t[15:8];
    endfunction

endpackage

>>> design/rxc_in_if.sv
// Input channel interface: valid/ready handshake with one message item.
// Depends on rxc_pkg.
interface rxc_in_if;
    logic                          valid;
    logic                          ready;
    logic [rxc_pkg::WORD_W-1:0]    data_word;
    logic [rxc_pkg::COUNT_W-1:0]   byte_count;
    logic                          message_start;

    modport source (output valid, data_word, byte_count, message_start, input ready);
    modport sink   (input valid, data_word, byte_count, message_start, output ready);
endinterface

>>> design/rxc_out_if.sv
// Output channel interface: valid/ready handshake with one result item.
// Depends on rxc_pkg.
interface rxc_out_if;
    logic                          valid;
    logic                          ready;
    logic [rxc_pkg::WORD_W-1:0]    result_word;
    logic [rxc_pkg::COUNT_W-1:0]   result_bytes;

    modport source (output valid, result_word, result_bytes, input ready);
    modport sink   (input valid, result_word, result_bytes, output ready);
endinterface

>>> design/rxc_apb_regs.sv
// APB configuration registers: decrypt mode and seed key.
// Depends on rxc_pkg.
module rxc_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rxc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rxc_pkg::t_cfg               o_cfg
);
    logic        r_decrypt;
    logic [31:0] r_seed;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_seed    <= rxc_pkg::SEED_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                rxc_pkg::REG_DECRYPT: r_decrypt <= pwdata[0];
                rxc_pkg::REG_SEED:    r_seed    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rxc_pkg::REG_DECRYPT: prdata = {31'd0, r_decrypt};
            rxc_pkg::REG_SEED:    prdata = r_seed;
            default:              prdata = 32'd0;
        endcase
    end

    assign o_cfg.decrypt = r_decrypt;
    assign o_cfg.seed    = r_seed;
endmodule

>>> design/rxc_xform.sv
// Word and tail-byte transform for one item, plus next chain state.
// Depends on rxc_pkg.
module rxc_xform (
    input  logic [rxc_pkg::WORD_W-1:0]  i_data,
    input  logic [rxc_pkg::COUNT_W-1:0] i_count,   // already clamped to 0..4
    input  logic                        i_start,
    input  rxc_pkg::t_cfg               i_cfg,
    input  rxc_pkg::t_chain             i_state,
    output logic [rxc_pkg::WORD_W-1:0]  o_result,
    output rxc_pkg::t_chain             o_state
);
    rxc_pkg::t_chain cur;
    logic [4:0]      rot;
    logic [31:0]     word_res;
    logic [31:0]     tail_res;
    logic [2:0]      n;
    logic [7:0]      b;
    logic [7:0]      kb;
    logic [7:0]      o;

    always_comb begin
        cur = i_start ? rxc_pkg::t_chain'{chain: i_cfg.seed, index: '0} : i_state;
        rot = rxc_pkg::ROT_TABLE[cur.index];

        if (!i_cfg.decrypt) begin
            word_res = rxc_pkg::rotr32(i_data, rot) ^ cur.chain;
        end else begin
            word_res = rxc_pkg::rotl32(i_data ^ cur.chain, rot);
        end

        // tail: byte chain of up to three steps
        tail_res = '0;
        n        = cur.index[2:0];
        for (int j = 0; j < 3; j++) begin
            b  = i_data[8*j +: 8];
            kb = i_cfg.seed[8*j +: 8];
            if (!i_cfg.decrypt) begin
                o = rxc_pkg::rotr8(b, n) ^ kb;
                n = o[2:0];
            end else begin
                o = rxc_pkg::rotl8(b ^ kb, n);
                n = b[2:0];
            end
            if (j < int'(i_count)) begin
                tail_res[8*j +: 8] = o;
            end
        end

        o_state = cur;
        if (i_count == rxc_pkg::FULL_COUNT) begin
            o_result = word_res;
            o_state.chain = i_cfg.decrypt ? i_data : word_res;
            o_state.index = i_cfg.decrypt ? i_data[28:24] : word_res[28:24];
        end else begin
            o_result = tail_res;
        end
    end
endmodule

>>> design/rotate_xor_chain_cipher_top.sv
// Top level of the rotate/XOR chain cipher.
// An accepted item is held in the input register, then moves to the output register once that is empty or taken.
// Throughput: one item per cycle while the output is ready; the chain state loop is one rotate and XOR.
// Reset (synchronous, active low): pipeline empty, chain 0, index 0,
// decrypt mode 0, seed key 16.
// Depends on rxc_pkg, rxc_in_if, rxc_out_if, rxc_apb_regs, rxc_xform.
module rotate_xor_chain_cipher_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rxc_in_if.sink                      i_in,
    rxc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rxc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    rxc_pkg::t_cfg               cfg;
    rxc_pkg::t_chain             r_state;
    rxc_pkg::t_chain             n_state;

    logic                        r_in_valid;
    logic [rxc_pkg::WORD_W-1:0]  r_in_data;
    logic [rxc_pkg::COUNT_W-1:0] r_in_count;
    logic                        r_in_start;

    logic                        r_out_valid;
    logic [rxc_pkg::WORD_W-1:0]  r_out_word;
    logic [rxc_pkg::COUNT_W-1:0] r_out_bytes;

    logic [rxc_pkg::WORD_W-1:0]  n_out_word;
    logic [rxc_pkg::COUNT_W-1:0] in_count_clamped;
    logic                        advance;
    logic                        in_xfer;

    rxc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rxc_xform u_xform (
        .i_data   (r_in_data),
        .i_count  (r_in_count),
        .i_start  (r_in_start),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_result (n_out_word),
        .o_state  (n_state)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    // counts of 5..7 act as a full word
    assign in_count_clamped = i_in.byte_count[2] ? rxc_pkg::FULL_COUNT : i_in.byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data  <= i_in.data_word;
            r_in_count <= in_count_clamped;
            r_in_start <= i_in.message_start;
        end
        if (advance) begin
            r_out_word  <= n_out_word;
            r_out_bytes <= r_in_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_word  = r_out_word;
    assign o_out.result_bytes = r_out_bytes;
endmodule

>>> verif/rotate_xor_chain_cipher_top_tb.sv
// Testbench for rotate_xor_chain_cipher_top: drives message items with bursty valid and
// stalling ready, predicts each result word in-bench and compares field by field.
// Depends on rxc_pkg, rxc_in_if, rxc_out_if and the design top.
`timescale 1ns / 100ps

module rotate_xor_chain_cipher_top_tb;

    localparam logic [rxc_pkg::ADDR_W-1:0] ADDR_DECRYPT = {rxc_pkg::REG_DECRYPT, 2'b00};
    localparam logic [rxc_pkg::ADDR_W-1:0] ADDR_SEED    = {rxc_pkg::REG_SEED, 2'b00};
    localparam int LONG_HOLD  = 48;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [rxc_pkg::WORD_W-1:0]  word;
        logic [rxc_pkg::COUNT_W-1:0] nbytes;
    } t_cipher_out;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_LIGHT, RDY_RUNS} t_rdy_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [rxc_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rxc_in_if  in_ch ();
    rxc_out_if out_ch ();

    rotate_xor_chain_cipher_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // in-bench copy of the cipher's config and chain state
    logic                       decrypt_cfg;
    logic [rxc_pkg::WORD_W-1:0] seed_cfg;
    logic [rxc_pkg::WORD_W-1:0] chain_q;
    logic [rxc_pkg::IDX_W-1:0]  index_q;

    t_cipher_out pending_cipher_q[$];
    int          mismatch_cnt = 0;
    int          burst_left = 0;
    bit          no_gaps = 0;
    bit          long_hold_req = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("rotate_xor_chain_cipher_top verification failed");
        $finish;
    end

    function automatic t_cipher_out predict_cipher(input logic [rxc_pkg::WORD_W-1:0] data,
                                                   input logic [rxc_pkg::COUNT_W-1:0] cnt_in,
                                                   input logic start);
        t_cipher_out                 r;
        logic [rxc_pkg::COUNT_W-1:0] cnt;
        logic [4:0]                  rot;
        logic [rxc_pkg::WORD_W-1:0]  t32;
        logic [2:0]                  n;
        logic [7:0]                  b;
        logic [7:0]                  kb;
        logic [7:0]                  t8;
        logic [7:0]                  o;
        r = '0;
        if (start) begin
            chain_q = seed_cfg;
            index_q = '0;
        end
        cnt = (cnt_in > rxc_pkg::FULL_COUNT) ? rxc_pkg::FULL_COUNT : cnt_in;
        if (cnt == rxc_pkg::FULL_COUNT) begin
            rot = rxc_pkg::ROT_TABLE[index_q];
            if (!decrypt_cfg) begin
                r.word = ((data >> rot) | (data << (6'd32 - rot))) ^ chain_q;
                chain_q = r.word;
                index_q = r.word[28:24];
            end else begin
                t32 = data ^ chain_q;
                r.word = (t32 << rot) | (t32 >> (6'd32 - rot));
                chain_q = data;
                index_q = data[28:24];
            end
        end else begin
            // tail bytes: byte chain keyed by seed bytes, chain state untouched
            n = index_q[2:0];
            for (int j = 0; j < 3; j++) begin
                if (j < cnt) begin
                    b  = data[8*j +: 8];
                    kb = seed_cfg[8*j +: 8];
                    if (!decrypt_cfg) begin
                        o = ((b >> n) | (b << (4'd8 - n))) ^ kb;
                        n = o[2:0];
                    end else begin
                        t8 = b ^ kb;
                        o = (t8 << n) | (t8 >> (4'd8 - n));
                        n = b[2:0];
                    end
                    r.word[8*j +: 8] = o;
                end
            end
        end
        r.nbytes = cnt;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (mismatch_cnt < MAX_REPORT)
            $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want, got);
        mismatch_cnt++;
    endtask

    // result check first, then prediction, so same-edge transfers never race
    always @(posedge i_clk) begin
        t_cipher_out got;
        t_cipher_out want;
        t_cipher_out predicted;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.word   = out_ch.result_word;
                got.nbytes = out_ch.result_bytes;
                if (pending_cipher_q.size() == 0) begin
                    log_mismatch("unexpected result", '0, got.word);
                end else begin
                    want = pending_cipher_q.pop_front();
                    if (got.word !== want.word)
                        log_mismatch("result_word", want.word, got.word);
                    if (got.nbytes !== want.nbytes)
                        log_mismatch("result_bytes", 32'(want.nbytes), 32'(got.nbytes));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predicted = predict_cipher(in_ch.data_word, in_ch.byte_count,
                                           in_ch.message_start);
                pending_cipher_q = {pending_cipher_q, predicted};
            end
        end
    end

    initial begin : sink_ready_gen
        t_rdy_mode mode;
        int        mode_left;
        int        run_left;
        logic      run_level;
        out_ch.ready = 1'b0;
        mode = RDY_ALWAYS;
        mode_left = 0;
        run_left = 0;
        run_level = 1'b1;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = t_rdy_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS: out_ch.ready <= 1'b1;
                    RDY_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_LIGHT:  out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_level = ~run_level;
                            run_left = $urandom_range(1, 12);
                        end
                        run_left--;
                        out_ch.ready <= run_level;
                    end
                endcase
            end
        end
    end

    // valid stays high across back-to-back transfers within a burst
    task automatic send_item(input logic [rxc_pkg::WORD_W-1:0] data,
                             input logic [rxc_pkg::COUNT_W-1:0] cnt,
                             input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.data_word     <= data;
        in_ch.byte_count    <= cnt;
        in_ch.message_start <= start;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_cipher_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rxc_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_DECRYPT)
            decrypt_cfg = value[0];
        else
            seed_cfg = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic mode, input logic [31:0] seed);
        wait_idle();
        write_reg(ADDR_DECRYPT, {31'b0, mode});
        write_reg(ADDR_SEED, seed);
    endtask

    function automatic logic [rxc_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_state();
        // reset chain is zero until the first restart; seed is the reset value
        send_item(32'h1234_5678, rxc_pkg::FULL_COUNT, 1'b0);
        send_item(32'hFFFF_FFFF, rxc_pkg::FULL_COUNT, 1'b0);
        send_item(32'h0000_00A5, 3'd1, 1'b0);
        send_item(32'hDEAD_BEEF, rxc_pkg::FULL_COUNT, 1'b1);
        send_item(32'h0000_0000, rxc_pkg::FULL_COUNT, 1'b0);
        send_item(32'hCAFE_F00D, 3'd3, 1'b0);
    endtask

    task automatic test_directed_cases();
        set_config(1'b0, 32'hFFFF_FFFF);
        send_item(32'h0000_0000, rxc_pkg::FULL_COUNT, 1'b1);
        send_item(32'hFFFF_FFFF, rxc_pkg::FULL_COUNT, 1'b0);
        send_item(32'h8000_0001, rxc_pkg::FULL_COUNT, 1'b0);
        send_item(32'hFFFF_FF5A, 3'd1, 1'b0);      // junk above the count
        send_item(32'hFFFF_00FF, 3'd2, 1'b0);
        send_item(32'hFF12_3456, 3'd3, 1'b0);
        send_item(32'hFFAB_CDEF, 3'd3, 1'b0);      // tail again, same start rotation
        send_item(32'hFFFF_FFFF, 3'd0, 1'b1);      // zero count, reload only
        send_item(32'h1122_3344, 3'd5, 1'b0);      // oversized counts act as full
        send_item(32'h5566_7788, 3'd6, 1'b0);
        send_item(32'h99AA_BBCC, 3'd7, 1'b0);
        send_item(32'h0000_00FF, 3'd2, 1'b1);      // restart on a tail
        set_config(1'b1, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, rxc_pkg::FULL_COUNT, 1'b1);
        send_item(32'h1234_5678, rxc_pkg::FULL_COUNT, 1'b0);
        send_item(32'h00FF_FF00, 3'd3, 1'b0);
        send_item(32'h0000_ABCD, 3'd0, 1'b0);
        send_item(32'h0102_0304, 3'd7, 1'b1);
    endtask

    task automatic test_random_messages(input logic mode, input logic [31:0] seed,
                                        input int n_items);
        int   sent;
        int   words;
        logic restart;
        set_config(mode, seed);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item($urandom, rxc_pkg::COUNT_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                words = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 6);
                restart = ($urandom_range(0, 5) != 0);
                for (int k = 0; k < words; k++)
                    send_item(random_word(), rxc_pkg::FULL_COUNT, restart && k == 0);
                sent += words;
                if ($urandom_range(0, 2) == 0) begin
                    send_item(random_word(), rxc_pkg::COUNT_W'($urandom_range(1, 3)), 1'b0);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_input_stall();
        set_config(1'b1, $urandom);
        no_gaps = 1;
        long_hold_req = 1;
        for (int k = 0; k < 30; k++)
            send_item(random_word(), rxc_pkg::FULL_COUNT, k == 0);
        no_gaps = 0;
    endtask

    initial begin : test_seq
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_word     = '0;
        in_ch.byte_count    = '0;
        in_ch.message_start = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        decrypt_cfg         = 1'b0;
        seed_cfg            = rxc_pkg::SEED_RESET;
        chain_q             = '0;
        index_q             = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed_cases();
        test_random_messages(1'b0, 32'h0000_0000, 100);
        test_random_messages(1'b1, 32'h0000_0000, 100);
        test_random_messages(1'b1, 32'hFFFF_FFFF, 100);
        test_random_messages(1'b0, $urandom, 100);
        test_random_messages(1'b1, $urandom, 100);
        test_random_messages(1'b0, 32'hFFFF_FFFF, 100);
        test_input_stall();

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_cipher_q.size() == 0) begin
            $display("rotate_xor_chain_cipher_top verification clean");
        end else begin
            $display("rotate_xor_chain_cipher_top verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/rxc_pkg.sv
design/rxc_in_if.sv
design/rxc_out_if.sv
design/rxc_apb_regs.sv
design/rxc_xform.sv
design/rotate_xor_chain_cipher_top.sv
verif/rotate_xor_chain_cipher_top_tb.sv
